// File: design/bft_pkg.sv
// bft_pkg: shared types and constants for the bitcell to flux timing core
// no dependencies; imported by bft_ctrl, bft_datapath, the top level and the checker
`timescale 1ns / 1ps

package bft_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_PERIOD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_CELLS = 4'd1;
    localparam int CFG_DATA_W = 32;

    // reset values of the configuration registers
    localparam logic [15:0] CELL_PERIOD_RESET = 16'd2304;
    localparam logic [23:0] TRACK_CELLS_RESET = 24'd100000;

    // fixed point and result limits
    localparam int FRAC_BITS = 4;
    localparam int MAX_RESULTS = 32;
    localparam int EMIT_CNT_W = 6;
    localparam int CELL_POS_W = 25;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CELL,
        ST_ADVANCE,
        ST_WRAP,
        ST_CLAMP,
        ST_MULT,
        ST_RECORD
    } bft_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // take a new word
        logic step;      // process one bitcell
        logic advance;   // move track position by one word
        logic wrap_chk;  // compare position to track length and wrap
        logic clamp;     // clear position if still past the track
        logic mult;      // position times cell period
        logic record;    // latch track length, rebase tick position
    } bft_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic blocked;   // current cell must emit but the output register is full and stalled
    } bft_status_t;

endpackage

// File: design/bft_ctrl.sv
// bft_ctrl: sequencer for the bitcell to flux timing core
// depends on bft_pkg; drives bft_datapath through bft_cmd_t
`timescale 1ns / 1ps

module bft_ctrl
    import bft_pkg::*;
#(
    parameter int WORD_CELLS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        word_valid,
    output logic        word_stall,
    input  bft_status_t status,
    output bft_cmd_t    cmd
);

    localparam int CNT_W = $clog2(WORD_CELLS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_CELLS - 1);

    bft_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        word_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                word_stall = 1'b0;
                if (word_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_CELL;
                end
            end
            ST_CELL:
            begin
                if (!status.blocked)
                begin
                    cmd.step = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_next = ST_ADVANCE;
                    end
                end
            end
            ST_ADVANCE:
            begin
                cmd.advance = 1'b1;
                state_next  = ST_WRAP;
            end
            ST_WRAP:
            begin
                cmd.wrap_chk = 1'b1;
                state_next   = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_RECORD;
            end
            ST_RECORD:
            begin
                cmd.record = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/bft_datapath.sv
// bft_datapath: tick accumulator, track position and output register
// depends on bft_pkg; commanded by bft_ctrl
`timescale 1ns / 1ps

module bft_datapath
    import bft_pkg::*;
#(
    parameter int WORD_CELLS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bft_cmd_t              cmd,
    output bft_status_t           status,
    input  logic [WORD_CELLS-1:0] bitcell_word,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  flux_valid,
    input  logic                  flux_stall,
    output logic [15:0]           flux_interval,
    output logic [31:0]           track_ticks,
    output logic                  last_of_word
);

    localparam logic [31:0] CELLS_32 = 32'(WORD_CELLS);
    localparam logic [CELL_POS_W-1:0] CELLS_POS = CELL_POS_W'(WORD_CELLS);
    localparam logic [EMIT_CNT_W-1:0] EMIT_LAST = EMIT_CNT_W'(MAX_RESULTS - 1);
    localparam logic [EMIT_CNT_W-1:0] EMIT_MAX = EMIT_CNT_W'(MAX_RESULTS);

    logic [15:0]             cell_period_reg;
    logic [23:0]             track_cells_reg;
    logic [31:0]             acc_reg, acc_next;
    logic [CELL_POS_W-1:0]   cell_pos_reg, cell_pos_next;
    logic [31:0]             tick_pos_reg, tick_pos_next;
    logic [31:0]             track_len_reg, track_len_next;
    logic                    wrap_reg, wrap_next;
    logic [31:0]             prod_reg;
    logic [WORD_CELLS-1:0]   shift_reg;
    logic [EMIT_CNT_W-1:0]   emit_cnt_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [15:0]             interval_reg;
    logic [31:0]             len_out_reg;
    logic                    last_reg;

    logic [32:0]             sum_wide;
    logic [31:0]             acc_sat;
    logic [27:0]             whole;
    logic [27:0]             whole_m1;
    logic [15:0]             interval;
    logic                    cur_bit;
    logic                    emit;
    logic                    out_free;
    logic                    rest_zero;
    logic                    pos_past;

    assign sum_wide = {1'b0, acc_reg} + {17'b0, cell_period_reg};
    // saturate on accumulator overflow
    assign acc_sat  = sum_wide[32] ? '1 : sum_wide[31:0];
    assign whole    = acc_sat[31:FRAC_BITS];
    assign whole_m1 = whole - 28'd1;

    always_comb
    begin
        if (whole == '0)
        begin
            interval = '0;
        end
        else if (whole_m1[27:16] != '0)
        begin
            interval = 16'hFFFF;
        end
        else
        begin
            interval = whole_m1[15:0];
        end
    end

    assign cur_bit   = shift_reg[WORD_CELLS-1];
    assign emit      = cur_bit && (emit_cnt_reg != EMIT_MAX);
    assign out_free  = !out_valid_reg || !flux_stall;
    assign rest_zero = (shift_reg[WORD_CELLS-2:0] == '0);
    assign pos_past  = (cell_pos_reg >= {1'b0, track_cells_reg});

    assign status.blocked = emit && !out_free;

    always_comb
    begin
        acc_next       = acc_reg;
        cell_pos_next  = cell_pos_reg;
        tick_pos_next  = tick_pos_reg;
        track_len_next = track_len_reg;
        wrap_next      = wrap_reg;
        out_valid_next = out_valid_reg && flux_stall;

        if (cmd.step)
        begin
            acc_next = acc_sat;
            if (cur_bit)
            begin
                // keep only the fraction after a transition
                acc_next = {{(32-FRAC_BITS){1'b0}}, acc_sat[FRAC_BITS-1:0]};
            end
            if (emit)
            begin
                out_valid_next = 1'b1;
            end
        end
        if (cmd.advance)
        begin
            cell_pos_next = cell_pos_reg + CELLS_POS;
            tick_pos_next = tick_pos_reg + 32'(32'(cell_period_reg) * CELLS_32);
        end
        if (cmd.wrap_chk)
        begin
            wrap_next = pos_past;
            if (pos_past)
            begin
                cell_pos_next = cell_pos_reg - {1'b0, track_cells_reg};
            end
        end
        if (cmd.clamp && wrap_reg && pos_past)
        begin
            cell_pos_next = '0;
        end
        if (cmd.record && wrap_reg)
        begin
            // new tick position is what remains past the wrap point
            track_len_next = tick_pos_reg - prod_reg;
            tick_pos_next  = prod_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_period_reg <= CELL_PERIOD_RESET;
            track_cells_reg <= TRACK_CELLS_RESET;
            acc_reg         <= '0;
            cell_pos_reg    <= '0;
            tick_pos_reg    <= '0;
            track_len_reg   <= '0;
            wrap_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            emit_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_CELL_PERIOD)
            begin
                cell_period_reg <= cfg_data[15:0];
            end
            if (cfg_we && cfg_index == CFG_TRACK_CELLS)
            begin
                track_cells_reg <= cfg_data[23:0];
            end
            acc_reg       <= acc_next;
            cell_pos_reg  <= cell_pos_next;
            tick_pos_reg  <= tick_pos_next;
            track_len_reg <= track_len_next;
            wrap_reg      <= wrap_next;
            out_valid_reg <= out_valid_next;
            if (cmd.load)
            begin
                emit_cnt_reg <= '0;
            end
            else if (cmd.step && emit)
            begin
                emit_cnt_reg <= emit_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            shift_reg <= bitcell_word;
        end
        else if (cmd.step)
        begin
            shift_reg <= {shift_reg[WORD_CELLS-2:0], 1'b0};
        end
        if (cmd.mult)
        begin
            prod_reg <= 32'({7'b0, cell_pos_reg} * {16'b0, cell_period_reg});
        end
        if (cmd.step && emit)
        begin
            interval_reg <= interval;
            len_out_reg  <= track_len_reg;
            last_reg     <= rest_zero || (emit_cnt_reg == EMIT_LAST);
        end
    end

    assign flux_valid    = out_valid_reg;
    assign flux_interval = interval_reg;
    assign track_ticks   = len_out_reg;
    assign last_of_word  = last_reg;

endmodule

// File: design/bitcell_to_flux_timing_core.sv
// bitcell_to_flux_timing_core: top level of the bitcell to flux interval converter
// depends on bft_pkg, bft_ctrl and bft_datapath
`timescale 1ns / 1ps

// Takes words of WORD_CELLS disk bitcells (first cell in the msb) and emits one
// flux interval beat per transition (set cell), in cell order, with last_of_word
// on the final beat of the word; track_ticks shows the track length recorded
// before the word. A word goes one bitcell per cycle, unless stalled, through the
// saturating tick accumulator, then through the track position update (advance,
// wrap, clamp, multiply, record); a new word is taken only after that. A cell with a
// transition waits while the output register is full and flux_stall is high.
// cfg_ready is always high; configuration must be written only while the core is idle; the core does not check.

module bitcell_to_flux_timing_core
    import bft_pkg::*;
#(
    parameter int WORD_CELLS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  word_valid,
    output logic                  word_stall,
    input  logic [WORD_CELLS-1:0] bitcell_word,
    output logic                  flux_valid,
    input  logic                  flux_stall,
    output logic [15:0]           flux_interval,
    output logic [31:0]           track_ticks,
    output logic                  last_of_word,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    bft_cmd_t    cmd;
    bft_status_t status;

    assign cfg_ready = 1'b1;

    bft_ctrl #(
        .WORD_CELLS (WORD_CELLS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .status     (status),
        .cmd        (cmd)
    );

    bft_datapath #(
        .WORD_CELLS (WORD_CELLS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .bitcell_word  (bitcell_word),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .flux_valid    (flux_valid),
        .flux_stall    (flux_stall),
        .flux_interval (flux_interval),
        .track_ticks   (track_ticks),
        .last_of_word  (last_of_word)
    );

endmodule

// File: design/bft_checker.sv
// bft_port_checks: port level checks for bitcell_to_flux_timing_core
// depends on bft_pkg; bound to the top level below
`timescale 1ns / 1ps

module bft_port_checks
    import bft_pkg::*;
#(
    parameter int WORD_CELLS = 32
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  word_valid,
    input logic                  word_stall,
    input logic [WORD_CELLS-1:0] bitcell_word,
    input logic                  flux_valid,
    input logic                  flux_stall,
    input logic [15:0]           flux_interval,
    input logic [31:0]           track_ticks,
    input logic                  last_of_word
);

    // a stalled result beat stays
    a_flux_hold: assert property (@(posedge clk) disable iff (!rst_n)
        flux_valid && flux_stall |=> flux_valid)
        else $error("flux beat dropped while stalled");

    a_flux_stable: assert property (@(posedge clk) disable iff (!rst_n)
        flux_valid && flux_stall |=> $stable(flux_interval) && $stable(track_ticks)
            && $stable(last_of_word))
        else $error("flux payload changed while stalled");

    // after a word is taken the core stays busy, holding word_stall high
    a_busy_after_word: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !word_stall |=> word_stall ##1 word_stall)
        else $error("core ready too soon after a word");

    // once idle, any pending beat closes its word
    a_idle_pending_last: assert property (@(posedge clk) disable iff (!rst_n)
        flux_valid && !word_stall |-> last_of_word)
        else $error("pending beat without last_of_word while idle");

endmodule

bind bitcell_to_flux_timing_core bft_port_checks #(
    .WORD_CELLS (WORD_CELLS)
) u_bft_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .word_valid    (word_valid),
    .word_stall    (word_stall),
    .bitcell_word  (bitcell_word),
    .flux_valid    (flux_valid),
    .flux_stall    (flux_stall),
    .flux_interval (flux_interval),
    .track_ticks   (track_ticks),
    .last_of_word  (last_of_word)
);

// File: verif/bft_checker.sv
// bft_checker: watches the word, flux and register channels of the core, predicts each
// flux interval beat and compares it with what the core emits
// depends on bft_pkg
`timescale 1ns / 1ps

module bft_checker
    import bft_pkg::*;
#(
    parameter int WORD_CELLS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  word_valid,
    input  logic                  word_stall,
    input  logic [WORD_CELLS-1:0] bitcell_word,
    input  logic                  flux_valid,
    input  logic                  flux_stall,
    input  logic [15:0]           flux_interval,
    input  logic [31:0]           track_ticks,
    input  logic                  last_of_word,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    checked
);

    typedef struct packed {
        logic [15:0] interval;
        logic [31:0] ticks;
        logic        last;
    } flux_beat_t;

    // predicted copy of the core's registers and track state
    logic [15:0]             period_cfg;
    logic [23:0]             track_cfg;
    logic [31:0]             tick_acc;
    logic [CELL_POS_W-1:0]   cell_pos;
    logic [31:0]             tick_pos;
    logic [31:0]             track_len;

    flux_beat_t expected_flux[$];

    task automatic flag_mismatch(input string what, input flux_beat_t want,
                                 input flux_beat_t got);
        errors++;
        if (errors <= 10)
            $display("%s: expected interval/track/last %0d/%0d/%b, got %0d/%0d/%b",
                     what, want.interval, want.ticks, want.last,
                     got.interval, got.ticks, got.last);
    endtask

    // walk the cells msb first, one beat per transition, then move the track position
    task automatic convert_word(input logic [WORD_CELLS-1:0] cells);
        logic [32:0] sum;
        logic [31:0] whole;
        flux_beat_t  held;
        logic        have_held;
        int          i;
        have_held = 1'b0;
        held = '0;
        for (i = WORD_CELLS - 1; i >= 0; i--)
        begin
            sum = {1'b0, tick_acc} + {17'd0, period_cfg};
            tick_acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (cells[i])
            begin
                if (have_held)
                    expected_flux.push_back(held);
                whole = tick_acc >> FRAC_BITS;
                if (whole == 32'd0)
                    held.interval = 16'd0;
                else if (whole - 32'd1 > 32'h0000_FFFF)
                    held.interval = 16'hFFFF;
                else
                    held.interval = 16'(whole - 32'd1);
                held.ticks = track_len;
                held.last = 1'b0;
                have_held = 1'b1;
                tick_acc = tick_acc & 32'h0000_000F;
            end
        end
        if (have_held)
        begin
            held.last = 1'b1;
            expected_flux.push_back(held);
        end

        cell_pos = cell_pos + CELL_POS_W'(WORD_CELLS);
        tick_pos = tick_pos + 32'(WORD_CELLS) * 32'(period_cfg);
        if (cell_pos >= CELL_POS_W'(track_cfg))
        begin
            cell_pos = cell_pos - CELL_POS_W'(track_cfg);
            // still past the end after one wrap: restart at cell zero
            if (cell_pos >= CELL_POS_W'(track_cfg))
                cell_pos = '0;
            track_len = tick_pos - 32'(cell_pos) * 32'(period_cfg);
            tick_pos = tick_pos - track_len;
        end
    endtask

    task automatic check_beat();
        flux_beat_t got;
        flux_beat_t want;
        got = {flux_interval, track_ticks, last_of_word};
        if (expected_flux.size() == 0)
        begin
            flag_mismatch("unexpected flux beat", '0, got);
        end
        else
        begin
            want = expected_flux.pop_front();
            checked++;
            if (got !== want)
                flag_mismatch($sformatf("flux beat %0d differs", checked), want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_cfg = CELL_PERIOD_RESET;
            track_cfg = TRACK_CELLS_RESET;
            tick_acc = '0;
            cell_pos = '0;
            tick_pos = '0;
            track_len = '0;
            errors = 0;
            checked = 0;
            expected_flux.delete();
        end
        else
        begin
            // compare first: a beat never belongs to a word taken at the same edge
            if (flux_valid && !flux_stall)
                check_beat();
            if (word_valid && !word_stall)
                convert_word(bitcell_word);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CELL_PERIOD: period_cfg = cfg_data[15:0];
                    CFG_TRACK_CELLS: track_cfg = cfg_data[23:0];
                    default: ;
                endcase
            end
        end
        pending = expected_flux.size();
    end

endmodule

// File: verif/bitcell_to_flux_timing_core_tb.sv
// bitcell_to_flux_timing_core_tb: drives words and register writes into the core,
// stalls the flux side at random and reports the verdict from bft_checker
// depends on bft_pkg, bft_checker and bitcell_to_flux_timing_core
`timescale 1ns / 1ps

module bitcell_to_flux_timing_core_tb
    import bft_pkg::*;
();

    localparam int WORD_CELLS = 32;
    localparam int ZERO_RUN_WORDS = 20;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_WORDS = 28;
    // no register lives at this index, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  word_valid;
    logic                  word_stall;
    logic [WORD_CELLS-1:0] bitcell_word;
    logic                  flux_valid;
    logic                  flux_stall = 1'b0;
    logic [15:0]           flux_interval;
    logic [31:0]           track_ticks;
    logic                  last_of_word;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int  errors;
    int  pending;
    int  checked;
    int  words_sent;
    int  reg_writes;
    logic calm;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    bitcell_to_flux_timing_core #(.WORD_CELLS(WORD_CELLS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .word_valid    (word_valid),
        .word_stall    (word_stall),
        .bitcell_word  (bitcell_word),
        .flux_valid    (flux_valid),
        .flux_stall    (flux_stall),
        .flux_interval (flux_interval),
        .track_ticks   (track_ticks),
        .last_of_word  (last_of_word),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    bft_checker #(.WORD_CELLS(WORD_CELLS)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .word_valid    (word_valid),
        .word_stall    (word_stall),
        .bitcell_word  (bitcell_word),
        .flux_valid    (flux_valid),
        .flux_stall    (flux_stall),
        .flux_interval (flux_interval),
        .track_ticks   (track_ticks),
        .last_of_word  (last_of_word),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending),
        .checked       (checked)
    );

    // flux side back pressure, off during the calm stretch
    always @(negedge clk)
        flux_stall <= !calm && ($urandom_range(0, 99) < 24);

    // called and returns at a falling edge; valid stays high until the caller drops it
    task automatic send_word(input logic [WORD_CELLS-1:0] cells);
        while (!calm && $urandom_range(0, 99) < 24)
        begin
            word_valid <= 1'b0;
            @(negedge clk);
        end
        word_valid <= 1'b1;
        bitcell_word <= cells;
        do
            @(posedge clk);
        while (word_stall);
        @(negedge clk);
        words_sent++;
    endtask

    // drain every expected beat, then let the track update of the last word finish
    task automatic settle();
        word_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (WORD_CELLS + 8) @(negedge clk);
    endtask

    // cfg_valid is dropped after each write before the task returns
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        reg_writes++;
    endtask

    initial
    begin
        logic [WORD_CELLS-1:0] w;
        logic [CFG_DATA_W-1:0] d;
        int p;
        int n;

        rst_n = 1'b0;
        word_valid = 1'b0;
        bitcell_word = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CELL_PERIOD;
        cfg_data = '0;
        calm = 1'b0;
        words_sent = 0;
        reg_writes = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: all cells set, none set, single edges, alternating
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0000);
        send_word(32'h8000_0000);
        send_word(32'h0000_0001);
        send_word(32'hAAAA_AAAA);
        send_word(32'h5555_5555);
        settle();

        // one-tick period and a one-word track: the track wraps on every word
        write_reg(CFG_CELL_PERIOD, 32'd16);
        write_reg(CFG_TRACK_CELLS, 32'd32);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0001);
        send_word(32'h1234_5678);
        settle();

        // period below one tick: intervals clamp at zero
        write_reg(CFG_CELL_PERIOD, 32'd0);
        send_word(32'hFFFF_FFFF);
        send_word(32'hF0F0_F0F0);
        settle();

        // longest period and track, interval saturates at 16 bits
        write_reg(CFG_CELL_PERIOD, 32'hFFFF_FFFF);
        write_reg(CFG_TRACK_CELLS, 32'hFFFF_FFFF);
        send_word(32'h0000_8000);
        send_word(32'hFFFF_FFFF);
        settle();

        // zero track length and a track shorter than a word: position cleared
        write_reg(CFG_CELL_PERIOD, 32'd5);
        write_reg(CFG_TRACK_CELLS, 32'd0);
        send_word(32'h0000_0001);
        send_word(32'h0000_0000);
        settle();
        write_reg(CFG_TRACK_CELLS, 32'd7);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        send_word(32'hC000_0003);
        send_word(32'h0001_0000);
        settle();

        // run of empty words at the largest period: the accumulator grows far
        // past the 16-bit interval range before the next transition
        write_reg(CFG_CELL_PERIOD, 32'd65535);
        write_reg(CFG_TRACK_CELLS, 32'd16777215);
        for (n = 0; n < ZERO_RUN_WORDS; n++)
            send_word(32'h0000_0000);
        send_word(32'h8000_0001);
        settle();
        write_reg(CFG_TRACK_CELLS, 32'd40);
        send_word(32'h0000_0400);
        send_word(32'h0000_0000);
        send_word(32'h0200_0000);
        settle();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            calm = (p == 2);
            d = $urandom;
            case ($urandom_range(0, 5))
                0: d[15:0] = 16'($urandom_range(16, 400));
                1: d[15:0] = 16'($urandom_range(0, 15));
                2: d[15:0] = 16'($urandom_range(0, 65535));
                default: d[15:0] = 16'($urandom_range(1500, 5000));
            endcase
            write_reg(CFG_CELL_PERIOD, d);
            d = $urandom;
            case ($urandom_range(0, 3))
                0: d[23:0] = 24'($urandom_range(32, 400));
                1: d[23:0] = 24'($urandom_range(0, 31));
                2: d[23:0] = 24'($urandom_range(1000, 200000));
                default: d[23:0] = 24'($urandom_range(0, 24'hFF_FFFF));
            endcase
            write_reg(CFG_TRACK_CELLS, d);
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                case ($urandom_range(0, 7))
                    1: w = $urandom & $urandom & $urandom;
                    2: w = $urandom | $urandom;
                    3: w = '0;
                    4: w = '1;
                    5: w = 32'h1 << $urandom_range(0, WORD_CELLS - 1);
                    default: w = $urandom;
                endcase
                send_word(w);
            end
            settle();
        end
        calm = 1'b0;

        $display("run covered %0d words (%0d in the empty run) and %0d register writes",
                 words_sent, ZERO_RUN_WORDS, reg_writes);
        $display("%0d flux intervals compared, %0d errors", checked, errors);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
design/bft_pkg.sv
design/bft_ctrl.sv
design/bft_datapath.sv
design/bitcell_to_flux_timing_core.sv
design/bft_checker.sv
verif/bft_checker.sv
verif/bitcell_to_flux_timing_core_tb.sv
